// ===== rtl/dsbd_pkg.sv =====
// ----------------------------------------------------------------------------
// dsbd_pkg
// Shared widths and status codes for the stored-block deframer.
// ----------------------------------------------------------------------------
package dsbd_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned StatusW = 3;
  localparam int unsigned LenW    = 16;

  typedef logic [ByteW-1:0]   byte_t;
  typedef logic [StatusW-1:0] status_t;
  typedef logic [LenW-1:0]    len_t;

  localparam status_t ST_OK       = 3'd0;
  localparam status_t ST_DONE     = 3'd1;
  localparam status_t ST_BADTYPE  = 3'd2;
  localparam status_t ST_CORRUPT  = 3'd3;
  localparam status_t ST_HUFFMAN  = 3'd4;
  localparam status_t ST_BADSTATE = 3'd5;

  // BTYPE field of the block header (bits 2:1)
  localparam logic [1:0] BTYPE_STORED = 2'd0;
  localparam logic [1:0] BTYPE_FIXED  = 2'd1;
  localparam logic [1:0] BTYPE_DYN    = 2'd2;
  localparam logic [1:0] BTYPE_RSVD   = 2'd3;

endpackage

// ===== rtl/dsbd_ifs.sv =====
// ----------------------------------------------------------------------------
// dsbd channel interfaces
// Valid/ready channels for payload bytes in and deframed results out.
// ----------------------------------------------------------------------------
interface dsbd_in_if;
  logic             valid;
  logic             ready;
  dsbd_pkg::byte_t  in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface dsbd_out_if;
  logic              valid;
  logic              ready;
  logic              out_valid;
  dsbd_pkg::byte_t   out_byte;
  dsbd_pkg::status_t status;

  modport source (output valid, output out_valid, output out_byte, output status,
                  input ready);
  modport sink   (input valid, input out_valid, input out_byte, input status,
                  output ready);
endinterface

// ===== rtl/deflate_stored_block_deframer.sv =====
// Pipeline: an accepted byte is held in the input register and moves into the result
// register when the pipeline advances, where its result transaction is offered on out_ch.
// Throughput: one byte per cycle while out_ch.ready does not stall; the input register
// and the result register form a two-stage pipeline that advances whenever the result
// register is free or being taken. Reset (rst_n low, synchronous) empties both stages
// and returns the parser to the header state; the LEN holding registers are not reset.
// ----------------------------------------------------------------------------
// deflate_stored_block_deframer
// Parses deflate block headers, checks LEN/NLEN of stored blocks and passes
// stored data through, one status per input byte.
// ----------------------------------------------------------------------------
module deflate_stored_block_deframer (
  input  logic       clk,
  input  logic       rst_n,
  dsbd_in_if.sink    in_ch,
  dsbd_out_if.source out_ch
);
  import dsbd_pkg::*;

  typedef enum logic [2:0] {
    MODE_HEADER = 3'd0,
    MODE_LENGTH = 3'd1,
    MODE_DATA   = 3'd2,
    MODE_DONE   = 3'd3,
    MODE_ERROR  = 3'd4
  } mode_t;

  // input stage
  logic    in_vld_r;
  byte_t   in_byte_r;
  // parser state
  mode_t   mode_r, mode_nxt;
  logic    final_r, final_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  byte_t   len_lo_r, len_hi_r;
  logic    lo_ok_r, lo_ok_nxt;
  len_t    left_r, left_nxt;
  // result stage
  logic    res_vld_r;
  logic    res_data_vld_r, res_data_vld_nxt;
  byte_t   res_byte_r, res_byte_nxt;
  status_t res_status_r, res_status_nxt;

  logic    advance;
  byte_t   b;
  len_t    len_full;
  len_t    left_dec;

  assign advance      = in_vld_r && (!res_vld_r || out_ch.ready);
  assign in_ch.ready  = !in_vld_r || advance;
  assign b            = in_byte_r;
  assign len_full     = {len_hi_r, len_lo_r};
  assign left_dec     = left_r - len_t'(1);

  assign out_ch.valid     = res_vld_r;
  assign out_ch.out_valid = res_data_vld_r;
  assign out_ch.out_byte  = res_byte_r;
  assign out_ch.status    = res_status_r;

  always_comb begin
    mode_nxt         = mode_r;
    final_nxt        = final_r;
    cnt_nxt          = cnt_r;
    lo_ok_nxt        = lo_ok_r;
    left_nxt         = left_r;
    res_data_vld_nxt = 1'b0;
    res_byte_nxt     = '0;
    res_status_nxt   = ST_OK;
    unique case (mode_r)
      MODE_HEADER: begin
        final_nxt = b[0];
        unique case (b[2:1]) inside
          BTYPE_STORED: begin
            mode_nxt = MODE_LENGTH;
            cnt_nxt  = 2'd0;
          end
          BTYPE_FIXED, BTYPE_DYN: begin
            mode_nxt       = MODE_ERROR;
            res_status_nxt = ST_HUFFMAN;
          end
          default: begin
            mode_nxt       = MODE_ERROR;
            res_status_nxt = ST_BADTYPE;
          end
        endcase
      end
      MODE_LENGTH: begin
        cnt_nxt = cnt_r + 2'd1;
        // NLEN low byte is checked on arrival, high byte at the end
        if (cnt_r == 2'd2) begin
          lo_ok_nxt = (~b == len_lo_r);
        end
        if (cnt_r == 2'd3) begin
          if (!lo_ok_r || (~b != len_hi_r)) begin
            mode_nxt       = MODE_ERROR;
            res_status_nxt = ST_CORRUPT;
          end else if (len_full != '0) begin
            left_nxt = len_full;
            mode_nxt = MODE_DATA;
          end else begin
            left_nxt = len_full;
            if (final_r) begin
              mode_nxt       = MODE_DONE;
              res_status_nxt = ST_DONE;
            end else begin
              mode_nxt = MODE_HEADER;
            end
          end
        end
      end
      MODE_DATA: begin
        res_data_vld_nxt = 1'b1;
        res_byte_nxt     = b;
        if (left_r != '0) begin
          left_nxt = left_dec;
        end
        if (left_r <= len_t'(1)) begin
          if (final_r) begin
            mode_nxt       = MODE_DONE;
            res_status_nxt = ST_DONE;
          end else begin
            mode_nxt = MODE_HEADER;
          end
        end
      end
      MODE_DONE: begin
        res_status_nxt = ST_DONE;
      end
      default: begin
        mode_nxt       = MODE_ERROR;
        res_status_nxt = ST_BADSTATE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      res_vld_r <= 1'b0;
      mode_r    <= MODE_HEADER;
      final_r   <= 1'b0;
      cnt_r     <= 2'd0;
      lo_ok_r   <= 1'b0;
      left_r    <= '0;
    end else begin
      if (in_ch.ready) begin
        in_vld_r <= in_ch.valid;
      end
      if (advance) begin
        res_vld_r <= 1'b1;
        mode_r    <= mode_nxt;
        final_r   <= final_nxt;
        cnt_r     <= cnt_nxt;
        lo_ok_r   <= lo_ok_nxt;
        left_r    <= left_nxt;
      end else if (out_ch.ready) begin
        res_vld_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_byte_r <= in_ch.in_byte;
    end
    if (advance) begin
      res_data_vld_r <= res_data_vld_nxt;
      res_byte_r     <= res_byte_nxt;
      res_status_r   <= res_status_nxt;
      if (mode_r == MODE_LENGTH && cnt_r == 2'd0) begin
        len_lo_r <= b;
      end
      if (mode_r == MODE_LENGTH && cnt_r == 2'd1) begin
        len_hi_r <= b;
      end
    end
  end

endmodule
